### rtl/chip8_instruction_core_unit_macros.svh
`ifndef CHIP8_INSTRUCTION_CORE_UNIT_MACROS_SVH
`define CHIP8_INSTRUCTION_CORE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define C8_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define C8_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/c8core_pkg.sv
package c8core_pkg;

	localparam int ADDR_W      = 12;
	localparam int MEM_DEPTH   = 4096;
	localparam int SCREEN_COLS = 64;
	localparam int SCREEN_ROWS = 32;
	localparam int NUM_VREGS   = 16;
	localparam int FONT_LEN    = 80;

	localparam logic [ADDR_W-1:0] START_PC  = 12'h200;
	localparam logic [ADDR_W-1:0] FONT_BASE = 12'h050;
	localparam logic [ADDR_W-1:0] FONT_END  = FONT_BASE + ADDR_W'(FONT_LEN);
	localparam logic [ADDR_W-1:0] PC_STEP   = 12'd2;
	localparam logic [3:0]        FLAG_REG  = 4'hF;
	localparam logic [7:0]        CLS_LOW   = 8'hE0;

	// hex glyphs 0..F, five rows each
	localparam logic [7:0] FONT [FONT_LEN] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_STEP  = 2'd1,
		OP_READ  = 2'd2,
		OP_SPARE = 2'd3
	} item_op_t;

	typedef enum logic [3:0] {
		INS_SYS  = 4'h0,
		INS_JUMP = 4'h1,
		INS_SET  = 4'h6,
		INS_ADD  = 4'h7,
		INS_SETI = 4'hA,
		INS_DRAW = 4'hD
	} ins_top_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_FETCH0,
		ST_FETCH1,
		ST_FETCH2,
		ST_EXEC,
		ST_DRAW_X,
		ST_DRAW_Y,
		ST_DRAW_ROW,
		ST_REPORT
	} state_t;

	typedef struct packed {
		item_op_t    opcode;
		logic [11:0] address;
		logic [7:0]  data;
		logic [4:0]  row_select;
		logic [3:0]  reg_select;
	} req_t;

	typedef struct packed {
		logic [11:0] program_counter;
		logic [11:0] index_value;
		logic [15:0] fetched_word;
		logic [7:0]  collision_flag;
		logic [7:0]  register_value;
		logic [63:0] pixel_row;
	} rsp_t;

	typedef struct packed {
		logic accept;
		logic clear_step;
		logic mem_load;
		logic fetch0;
		logic fetch1;
		logic fetch2;
		logic exec;
		logic draw_x;
		logic draw_y;
		logic draw_row;
		logic report;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic is_draw;
		logic n_zero;
		logic draw_last;
		logic out_free;
	} status_t;

endpackage

### rtl/chip8_instruction_core_unit.sv
// channel  beat    handshake              timing
// req      req_t   req_valid / req_stall  taken only when the core is idle
// rsp      rsp_t   rsp_valid / rsp_stall  one beat per req beat, registered
//
// States: IDLE, LOAD (load) or FETCH0-2, EXEC [DRAW_X, DRAW_Y, DRAW_ROW per row], REPORT.
// Draw cost is set by the single program memory read port, one sprite byte per cycle.
// After reset a sweep of all 4096 addresses writes memory (zero, font at 0x50) with req stalled.
// A stalled rsp beat holds the core in its report step; the next item waits for that slot.
module chip8_instruction_core_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  c8core_pkg::req_t req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output c8core_pkg::rsp_t rsp
);

	c8core_pkg::cmd_t    cmd;
	c8core_pkg::status_t status;

	c8core_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.opcode),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	c8core_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

### rtl/c8core_ctrl.sv
module c8core_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  c8core_pkg::item_op_t req_op,
	output logic                req_stall,
	input  c8core_pkg::status_t status,
	output c8core_pkg::cmd_t    cmd
);

	c8core_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= c8core_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			c8core_pkg::ST_CLEAR: begin
				if (status.clear_last) state_nxt = c8core_pkg::ST_IDLE;
			end
			c8core_pkg::ST_IDLE: begin
				if (req_valid) begin
					case (req_op)
						c8core_pkg::OP_LOAD: state_nxt = c8core_pkg::ST_LOAD;
						c8core_pkg::OP_STEP: state_nxt = c8core_pkg::ST_FETCH0;
						default:             state_nxt = c8core_pkg::ST_REPORT;
					endcase
				end
			end
			c8core_pkg::ST_LOAD:   state_nxt = c8core_pkg::ST_REPORT;
			c8core_pkg::ST_FETCH0: state_nxt = c8core_pkg::ST_FETCH1;
			c8core_pkg::ST_FETCH1: state_nxt = c8core_pkg::ST_FETCH2;
			c8core_pkg::ST_FETCH2: state_nxt = c8core_pkg::ST_EXEC;
			c8core_pkg::ST_EXEC: begin
				state_nxt = status.is_draw ? c8core_pkg::ST_DRAW_X : c8core_pkg::ST_REPORT;
			end
			c8core_pkg::ST_DRAW_X: state_nxt = c8core_pkg::ST_DRAW_Y;
			c8core_pkg::ST_DRAW_Y: begin
				state_nxt = status.n_zero ? c8core_pkg::ST_REPORT : c8core_pkg::ST_DRAW_ROW;
			end
			c8core_pkg::ST_DRAW_ROW: begin
				if (status.draw_last) state_nxt = c8core_pkg::ST_REPORT;
			end
			c8core_pkg::ST_REPORT: begin
				if (status.out_free) state_nxt = c8core_pkg::ST_IDLE;
			end
			default: state_nxt = c8core_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		req_stall      = 1'b1;
		case (state_q)
			c8core_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
			c8core_pkg::ST_IDLE: begin
				req_stall  = 1'b0;
				cmd.accept = req_valid;
			end
			c8core_pkg::ST_LOAD:     cmd.mem_load = 1'b1;
			c8core_pkg::ST_FETCH0:   cmd.fetch0   = 1'b1;
			c8core_pkg::ST_FETCH1:   cmd.fetch1   = 1'b1;
			c8core_pkg::ST_FETCH2:   cmd.fetch2   = 1'b1;
			c8core_pkg::ST_EXEC:     cmd.exec     = 1'b1;
			c8core_pkg::ST_DRAW_X:   cmd.draw_x   = 1'b1;
			c8core_pkg::ST_DRAW_Y:   cmd.draw_y   = 1'b1;
			c8core_pkg::ST_DRAW_ROW: cmd.draw_row = 1'b1;
			c8core_pkg::ST_REPORT:   cmd.report   = 1'b1;
			default: ;
		endcase
	end

`include "chip8_instruction_core_unit_macros.svh"

	`C8_AST_NXT(a_busy_after_accept, cmd.accept, req_stall, "item taken while busy")
	`C8_AST_IMP(a_clear_no_accept, state_q == c8core_pkg::ST_CLEAR, !cmd.accept,
		"item taken during memory sweep")
	`C8_AST_NXT(a_report_leaves, cmd.report && status.out_free,
		state_q == c8core_pkg::ST_IDLE, "report did not retire item")

endmodule

### rtl/c8core_dpath.sv
module c8core_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  c8core_pkg::req_t    req,
	input  c8core_pkg::cmd_t    cmd,
	output c8core_pkg::status_t status,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output c8core_pkg::rsp_t    rsp
);

	logic [7:0]  mem [c8core_pkg::MEM_DEPTH];
	logic [7:0]  mem_rd_q;
	logic        mem_we;
	logic [11:0] mem_wa, mem_ra, font_off;
	logic [7:0]  mem_wd;

	logic [11:0] clr_addr_q;
	c8core_pkg::req_t req_q;
	logic [7:0]  hi_q;
	logic [15:0] word_q;
	logic [11:0] pc_q, idx_q;
	logic [7:0]  vreg_q [c8core_pkg::NUM_VREGS];
	logic [63:0] scr_q [c8core_pkg::SCREEN_ROWS];
	logic [5:0]  x_q;
	logic [4:0]  y_q;
	logic [3:0]  r_q;

	c8core_pkg::rsp_t rsp_q;
	logic        rsp_valid_q, out_load;

	logic [3:0]  op_x, op_y, op_n, reg_ra;
	logic [7:0]  op_nn, reg_rd;
	logic [4:0]  scr_ra;
	logic [63:0] scr_rd, mask;
	logic [5:0]  row_sum, next_sum;
	logic [3:0]  r_nxt;
	c8core_pkg::ins_top_t top;

	assign top   = c8core_pkg::ins_top_t'(word_q[15:12]);
	assign op_x  = word_q[11:8];
	assign op_y  = word_q[7:4];
	assign op_n  = word_q[3:0];
	assign op_nn = word_q[7:0];

	assign r_nxt    = r_q + 4'd1;
	assign row_sum  = {1'b0, y_q} + {2'b00, r_q};
	assign next_sum = {1'b0, y_q} + {2'b00, r_nxt};
	assign mask     = {mem_rd_q, 56'd0} >> x_q;
	assign font_off = clr_addr_q - c8core_pkg::FONT_BASE;

	always_comb begin
		if (cmd.clear_step) begin
			mem_wa = clr_addr_q;
			if (clr_addr_q >= c8core_pkg::FONT_BASE && clr_addr_q < c8core_pkg::FONT_END) begin
				mem_wd = c8core_pkg::FONT[font_off[6:0]];
			end else begin
				mem_wd = 8'd0;
			end
		end else begin
			mem_wa = req_q.address;
			mem_wd = req_q.data;
		end
		mem_we = cmd.clear_step | cmd.mem_load;
	end

	always_comb begin
		if (cmd.fetch0) begin
			mem_ra = pc_q;
		end else if (cmd.fetch1) begin
			mem_ra = pc_q + 12'd1;
		end else if (cmd.draw_y) begin
			mem_ra = idx_q;
		end else if (cmd.draw_row) begin
			mem_ra = idx_q + {8'd0, r_nxt};
		end else begin
			mem_ra = pc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_addr_q <= clr_addr_q + 12'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) req_q <= req;
		if (cmd.fetch1) hi_q <= mem_rd_q;
		if (cmd.fetch2) word_q <= {hi_q, mem_rd_q};
		if (cmd.draw_x) x_q <= reg_rd[5:0];
		if (cmd.draw_y) begin
			y_q <= reg_rd[4:0];
			r_q <= '0;
		end else if (cmd.draw_row) begin
			r_q <= r_nxt;
		end
	end

	always_comb begin
		if (cmd.report) begin
			reg_ra = req_q.reg_select;
		end else if (cmd.draw_y) begin
			reg_ra = op_y;
		end else begin
			reg_ra = op_x;
		end
		scr_ra = cmd.report ? req_q.row_select : row_sum[4:0];
	end

	assign reg_rd = vreg_q[reg_ra];
	assign scr_rd = scr_q[scr_ra];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= c8core_pkg::START_PC;
			idx_q <= '0;
			for (int i = 0; i < c8core_pkg::NUM_VREGS; i++) vreg_q[i] <= '0;
		end else begin
			if (cmd.exec) begin
				pc_q <= (top == c8core_pkg::INS_JUMP) ? word_q[11:0] : pc_q + c8core_pkg::PC_STEP;
				case (top)
					c8core_pkg::INS_SET:  vreg_q[op_x] <= op_nn;
					c8core_pkg::INS_ADD:  vreg_q[op_x] <= reg_rd + op_nn;
					c8core_pkg::INS_SETI: idx_q <= word_q[11:0];
					default: ;
				endcase
			end
			if (cmd.draw_y) vreg_q[c8core_pkg::FLAG_REG] <= 8'd0;
			if (cmd.draw_row && (scr_rd & mask) != 64'd0) begin
				vreg_q[c8core_pkg::FLAG_REG] <= 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < c8core_pkg::SCREEN_ROWS; i++) scr_q[i] <= '0;
		end else if (cmd.exec && top == c8core_pkg::INS_SYS && op_nn == c8core_pkg::CLS_LOW) begin
			for (int i = 0; i < c8core_pkg::SCREEN_ROWS; i++) scr_q[i] <= '0;
		end else if (cmd.draw_row) begin
			scr_q[row_sum[4:0]] <= scr_rd ^ mask;
		end
	end

	// result register parts the core from the consumer
	assign out_load = cmd.report && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q.program_counter <= pc_q;
			rsp_q.index_value     <= idx_q;
			rsp_q.fetched_word    <= (req_q.opcode == c8core_pkg::OP_STEP) ? word_q : 16'd0;
			rsp_q.collision_flag  <= vreg_q[c8core_pkg::FLAG_REG];
			rsp_q.register_value  <= reg_rd;
			rsp_q.pixel_row       <= scr_rd;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign status.clear_last = (clr_addr_q == 12'hFFF);
	assign status.is_draw    = (top == c8core_pkg::INS_DRAW);
	assign status.n_zero     = (op_n == 4'd0);
	assign status.draw_last  = (r_nxt == op_n) || next_sum[5];
	assign status.out_free   = !rsp_valid_q || !rsp_stall;

`include "chip8_instruction_core_unit_macros.svh"

	`C8_AST_NXT(a_jump_pc, cmd.exec && top == c8core_pkg::INS_JUMP,
		pc_q == $past(word_q[11:0]), "jump target not taken")
	`C8_AST_NXT(a_step_pc, cmd.exec && top != c8core_pkg::INS_JUMP,
		pc_q == $past(pc_q + c8core_pkg::PC_STEP), "pc did not advance by two")
	`C8_AST_IMP(a_draw_clip, cmd.draw_row, !row_sum[5] && r_q < op_n,
		"sprite row outside screen or height")

endmodule

### tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import c8core_pkg::*;

	localparam int N_RANDOM  = 500;
	localparam int LONG_HOLD = 400;
	localparam int TAIL      = 40;
	localparam logic [7:0] RET_LOW = 8'hEE;
	localparam rsp_t RESET_VIEW = {START_PC, 12'h000, 16'h0000, 8'h00, 8'h00, 64'h0};

	typedef struct {
		req_t beat;
		bit   typed;
		rsp_t view;
	} plan_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// shadow of the core state
	logic [7:0]  mem_img [MEM_DEPTH];
	logic [7:0]  v_img   [NUM_VREGS];
	logic [63:0] scr_img [SCREEN_ROWS];
	logic [11:0] pc_img;
	logic [11:0] idx_img;

	rsp_t      exp_views [$];
	plan_row_t plan [$];
	int        n_faults   = 0;
	int        n_views    = 0;
	int        burst_left = 0;
	rsp_t      want;

	chip8_instruction_core_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial forever #6 clk = ~clk;

	initial begin
		#5000000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic rsp_t predict_view(req_t b);
		rsp_t        v;
		logic [15:0] w;
		int          x;
		int          y;
		logic [63:0] mask;
		w = '0;
		case (b.opcode)
			OP_LOAD: mem_img[b.address] = b.data;
			OP_STEP: begin
				w = {mem_img[pc_img], mem_img[pc_img + 12'd1]};
				pc_img = pc_img + PC_STEP;
				case (w[15:12])
					INS_SYS: begin
						if (w[7:0] == CLS_LOW)
							foreach (scr_img[i]) scr_img[i] = '0;
					end
					INS_JUMP: pc_img = w[11:0];
					INS_SET:  v_img[w[11:8]] = w[7:0];
					INS_ADD:  v_img[w[11:8]] = v_img[w[11:8]] + w[7:0];
					INS_SETI: idx_img = w[11:0];
					INS_DRAW: begin
						x = v_img[w[11:8]] % SCREEN_COLS;
						y = v_img[w[7:4]] % SCREEN_ROWS;
						v_img[FLAG_REG] = 8'h00;
						for (int r = 0; r < int'(w[3:0]); r++) begin
							if (y + r < SCREEN_ROWS) begin
								mask = {mem_img[idx_img + 12'(r)], 56'h0} >> x;
								if ((scr_img[y + r] & mask) != '0)
									v_img[FLAG_REG] = 8'h01;
								scr_img[y + r] ^= mask;
							end
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		v.program_counter = pc_img;
		v.index_value     = idx_img;
		v.fetched_word    = w;
		v.collision_flag  = v_img[FLAG_REG];
		v.register_value  = v_img[b.reg_select];
		v.pixel_row       = scr_img[b.row_select];
		return v;
	endfunction

	function automatic req_t beat_of(item_op_t op, logic [11:0] a, logic [7:0] d);
		req_t b;
		b.opcode     = op;
		b.address    = a;
		b.data       = d;
		b.row_select = 5'($urandom);
		b.reg_select = 4'($urandom);
		return b;
	endfunction

	function automatic void plan_ins(logic [11:0] at, logic [15:0] w);
		plan.push_back('{beat_of(OP_LOAD, at, w[15:8]), 1'b0, '0});
		plan.push_back('{beat_of(OP_LOAD, at + 12'd1, w[7:0]), 1'b0, '0});
		plan.push_back('{beat_of(OP_STEP, 12'($urandom), 8'($urandom)), 1'b0, '0});
	endfunction

	function automatic logic [15:0] pick_word();
		logic [15:0] w;
		logic [11:0] at;
		case ($urandom_range(0, 19))
			0:          w = {INS_SYS, 4'h0, CLS_LOW};
			1:          w = {INS_SYS, 4'h0, RET_LOW};
			2, 3:       w = {INS_JUMP, 12'($urandom)};
			4, 5, 6, 7: w = {INS_SET, 12'($urandom)};
			8, 9, 10:   w = {INS_ADD, 12'($urandom)};
			11, 12: begin
				case ($urandom_range(0, 2))
					0:       at = FONT_BASE + 12'(5 * $urandom_range(0, 15));
					1:       at = 12'hFF0 + 12'($urandom_range(0, 15));
					default: at = 12'($urandom);
				endcase
				w = {INS_SETI, at};
			end
			13, 14, 15, 16, 17: w = {INS_DRAW, 12'($urandom)};
			default:            w = 16'($urandom);
		endcase
		return w;
	endfunction

	task automatic send_beat(req_t b, bit typed = 1'b0, rsp_t view = '0);
		int   gap;
		rsp_t guess;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				req_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= b;
		do
			@(posedge clk);
		while (req_stall);
		guess = predict_view(b);
		exp_views.push_back(typed ? view : guess);
	endtask

	initial begin
		int          kind;
		int          n_sent;
		logic [15:0] w;
		foreach (mem_img[i]) mem_img[i] = '0;
		for (int i = 0; i < FONT_LEN; i++) mem_img[FONT_BASE + 12'(i)] = FONT[i];
		foreach (v_img[i]) v_img[i] = '0;
		foreach (scr_img[i]) scr_img[i] = '0;
		pc_img  = START_PC;
		idx_img = '0;

		plan.push_back('{beat_of(OP_READ, 12'hFFF, 8'hFF), 1'b1, RESET_VIEW});
		plan.push_back('{beat_of(OP_SPARE, 12'h000, 8'h00), 1'b1, RESET_VIEW});
		plan.push_back('{beat_of(OP_LOAD, 12'hFFF, 8'hFF), 1'b1, RESET_VIEW});
		plan_ins(12'h200, {INS_SET, 4'h0, 8'hFF});
		plan_ins(12'h202, {INS_ADD, 4'h0, 8'h02});
		plan_ins(12'h204, {INS_SETI, FONT_BASE});
		plan_ins(12'h206, {INS_DRAW, 4'h0, 4'h1, 4'h5});
		plan_ins(12'h208, {INS_DRAW, 4'h0, 4'h1, 4'h5});
		plan_ins(12'h20A, {INS_DRAW, 4'hF, 4'h0, 4'h0});
		plan_ins(12'h20C, {INS_SYS, 4'h0, RET_LOW});
		plan_ins(12'h20E, {INS_SYS, 4'h0, CLS_LOW});
		plan_ins(12'h210, {INS_JUMP, 12'hFFF});
		// fetch straddles the top of memory
		plan.push_back('{beat_of(OP_STEP, 12'h000, 8'h00), 1'b0, '0});

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) send_beat(plan[i].beat, plan[i].typed, plan[i].view);

		n_sent = 0;
		while (n_sent < N_RANDOM) begin
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				w = pick_word();
				send_beat(beat_of(OP_LOAD, pc_img, w[15:8]));
				send_beat(beat_of(OP_LOAD, pc_img + 12'd1, w[7:0]));
				send_beat(beat_of(OP_STEP, 12'($urandom), 8'($urandom)));
				n_sent += 3;
			end else begin
				case (kind)
					14, 15: send_beat(beat_of(OP_LOAD,
						idx_img + 12'($urandom_range(0, 15)), 8'($urandom)));
					16: send_beat(beat_of(OP_LOAD, 12'($urandom), 8'($urandom)));
					17: send_beat(beat_of(OP_READ, 12'($urandom), 8'($urandom)));
					18: send_beat(beat_of(OP_STEP, 12'($urandom), 8'($urandom)));
					default: send_beat(beat_of(OP_SPARE, 12'($urandom), 8'($urandom)));
				endcase
				n_sent++;
			end
		end
		@(negedge clk);
		req_valid <= 1'b0;

		while (exp_views.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (n_faults == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// receiver stall pattern, with one long hold-off to back the core up
	initial begin
		int mode;
		int len;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && n_views >= 60) begin
				held = 1'b1;
				repeat (LONG_HOLD) begin
					@(negedge clk);
					rsp_stall <= 1'b1;
				end
			end
			mode = $urandom_range(0, 3);
			len  = $urandom_range(4, 40);
			repeat (len) begin
				@(negedge clk);
				case (mode)
					0:       rsp_stall <= 1'b0;
					1:       rsp_stall <= ($urandom_range(0, 3) == 0);
					2:       rsp_stall <= 1'($urandom_range(0, 1));
					default: rsp_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			n_views++;
			if (exp_views.size() == 0) begin
				if (n_faults < 10)
					$display("rsp beat %0d with nothing outstanding: %p", n_views, rsp);
				n_faults++;
			end else begin
				want = exp_views.pop_front();
				if (rsp.program_counter !== want.program_counter
						|| rsp.index_value !== want.index_value
						|| rsp.fetched_word !== want.fetched_word
						|| rsp.collision_flag !== want.collision_flag
						|| rsp.register_value !== want.register_value
						|| rsp.pixel_row !== want.pixel_row) begin
					if (n_faults < 10) begin
						$display("rsp beat %0d mismatch", n_views);
						$display("  exp pc %h i %h w %h vf %h v %h row %h",
							want.program_counter, want.index_value, want.fetched_word,
							want.collision_flag, want.register_value, want.pixel_row);
						$display("  got pc %h i %h w %h vf %h v %h row %h",
							rsp.program_counter, rsp.index_value, rsp.fetched_word,
							rsp.collision_flag, rsp.register_value, rsp.pixel_row);
					end
					n_faults++;
				end
			end
		end
	end

endmodule

### filelist.f
+incdir+rtl
rtl/c8core_pkg.sv
rtl/c8core_ctrl.sv
rtl/c8core_dpath.sv
rtl/chip8_instruction_core_unit.sv
tb/tb_top.sv
